>>> src/tdl_pkg.sv
// Shared types and constants for the three-phase duty limiter.
`default_nettype none

package tdl_pkg;

  localparam int DUTY_W               = 16;
  localparam int PHASES               = 3;
  localparam int SCALE_FRAC_BITS_DEF  = 15;
  localparam logic [DUTY_W-1:0] CEILING_RESET = 16'd7000;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_SHIFT = 2'd1,
    ACT_SCALE = 2'd2
  } tdl_action_e;

  // One duty triple on its way down the pipeline
  typedef struct packed {
    logic [PHASES-1:0][DUTY_W-1:0] duty;
    logic [DUTY_W-1:0]             hi;
    logic [DUTY_W-1:0]             excess;
    tdl_action_e                   action;
  } tdl_item_t;

endpackage

`default_nettype wire

>>> src/tdl_div_step.sv
// One restoring-division step of the scale-factor pipeline (one quotient bit).
`default_nettype none

module tdl_div_step import tdl_pkg::*; #(
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire tdl_item_t                  item_i,
  input  wire logic [DUTY_W-1:0]          rem_i,
  input  wire logic [SCALE_FRAC_BITS-1:0] quot_i,
  output      tdl_item_t                  item_o,
  output      logic [DUTY_W-1:0]          rem_o,
  output      logic [SCALE_FRAC_BITS-1:0] quot_o
);

  tdl_item_t                  item_q;
  logic [DUTY_W-1:0]          rem_q, rem_d;
  logic [SCALE_FRAC_BITS-1:0] quot_q, quot_d;
  logic [DUTY_W:0]            trial;
  logic [DUTY_W:0]            diff;
  logic                       take;

  always_comb begin
    trial  = {rem_i, 1'b0};
    diff   = trial - {1'b0, item_i.hi};
    take   = (trial >= {1'b0, item_i.hi});
    // remainder stays below the divisor, so it fits back in DUTY_W bits
    rem_d  = take ? diff[DUTY_W-1:0] : trial[DUTY_W-1:0];
    quot_d = {quot_i[SCALE_FRAC_BITS-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign item_o = item_q;
  assign rem_o  = rem_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> src/tdl_lane.sv
// Per-phase lane: applies pass, common-mode shift or proportional scaling.
`default_nettype none

module tdl_lane import tdl_pkg::*; #(
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [DUTY_W-1:0]          duty_i,
  input  wire logic [DUTY_W-1:0]          excess_i,
  input  wire logic [SCALE_FRAC_BITS-1:0] factor_i,
  input  wire tdl_action_e                action_i,
  output      logic [DUTY_W-1:0]          duty_o
);

  logic [DUTY_W+SCALE_FRAC_BITS-1:0] prod;
  logic [DUTY_W-1:0]                 duty_q, duty_d;

  always_comb begin
    prod = {{SCALE_FRAC_BITS{1'b0}}, duty_i} * {{DUTY_W{1'b0}}, factor_i};
    case (action_i)
      ACT_PASS:  duty_d = duty_i;
      ACT_SHIFT: duty_d = duty_i - excess_i;
      ACT_SCALE: duty_d = prod[DUTY_W+SCALE_FRAC_BITS-1:SCALE_FRAC_BITS];
      default:   duty_d = duty_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

`default_nettype wire

>>> src/three_phase_duty_limiter.sv
// Top level of the three-phase duty limiter.
//
// Usage:
//   s_axis carries one duty triple per transfer (phase A in the low 16 bits).
//   m_axis returns the limited triple in the same layout, with the action
//   taken (pass, common-mode shift, proportional scaling) on tuser.
//   cfg_* writes the duty ceiling; it is always ready and must only be
//   written while no triple is in flight.
//   Throughput: one triple per cycle while the receiver does not stall. A
//   triple passes the input stage, the max/min stage, the scale-factor
//   divider, which resolves one quotient bit per pipeline stage, and the lane stage.
//   Each stage holds its own valid bit, so bubbles close up: while the
//   receiver stalls, new triples are still taken until every stage is full,
//   and the result in the output stage holds steady until transferred.
//   Reset clears all valid bits and loads the ceiling with 7000.
`default_nettype none

module three_phase_duty_limiter import tdl_pkg::*; #(
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // fields from bit 0: duty_in_a[15:0], duty_in_b[31:16], duty_in_c[47:32]
  input  wire logic [47:0]           s_axis_tdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  // fields from bit 0: duty_out_a[15:0], duty_out_b[31:16], duty_out_c[47:32]
  output      logic [47:0]           m_axis_tdata_o,
  // fields from bit 0: limit_action[1:0]
  output      logic [1:0]            m_axis_tuser_o,
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [DUTY_W-1:0]     cfg_data_i
);

  // input, max/min, divider steps, lanes
  localparam int NSTAGE = SCALE_FRAC_BITS + 3;
  localparam int LANE_S = SCALE_FRAC_BITS + 2;

  logic [DUTY_W-1:0] ceil_q;
  logic [NSTAGE-1:0] vld_q, vld_d;
  logic [NSTAGE:0]   ready;

  // ceiling register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= CEILING_RESET;
    end else if (cfg_valid_i) begin
      ceil_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  // valid chain: a stage loads when it is empty or its successor moves
  assign ready[NSTAGE] = m_axis_tready_i;
  for (genvar k = 0; k < NSTAGE; k++) begin : g_rdy
    assign ready[k] = !vld_q[k] || ready[k+1];
  end
  assign vld_d = {vld_q[NSTAGE-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (ready[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end
  assign s_axis_tready_o = ready[0];

  // stage 0: input register
  logic [PHASES-1:0][DUTY_W-1:0] in_duty_q;
  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      in_duty_q <= s_axis_tdata_i;
    end
  end

  // stage 1: largest and smallest duty
  logic [DUTY_W-1:0] mx_ab, mn_ab, hi_d, lo_d;
  logic [DUTY_W-1:0] hi_q, lo_q;
  logic [PHASES-1:0][DUTY_W-1:0] mm_duty_q;

  always_comb begin
    mx_ab = (in_duty_q[0] > in_duty_q[1]) ? in_duty_q[0] : in_duty_q[1];
    mn_ab = (in_duty_q[0] < in_duty_q[1]) ? in_duty_q[0] : in_duty_q[1];
    hi_d  = (in_duty_q[2] > mx_ab) ? in_duty_q[2] : mx_ab;
    lo_d  = (in_duty_q[2] < mn_ab) ? in_duty_q[2] : mn_ab;
  end

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      mm_duty_q <= in_duty_q;
    end
  end

  // action decision, fed into the first divider step
  tdl_item_t                  item_s [SCALE_FRAC_BITS+1];
  logic [DUTY_W-1:0]          rem_s  [SCALE_FRAC_BITS+1];
  logic [SCALE_FRAC_BITS-1:0] quot_s [SCALE_FRAC_BITS+1];
  logic [DUTY_W-1:0]          excess;

  always_comb begin
    excess           = hi_q - ceil_q;
    item_s[0].duty   = mm_duty_q;
    item_s[0].hi     = hi_q;
    item_s[0].excess = excess;
    if (hi_q <= ceil_q) begin
      item_s[0].action = ACT_PASS;
    end else if (lo_q >= excess) begin
      item_s[0].action = ACT_SHIFT;
    end else begin
      item_s[0].action = ACT_SCALE;
    end
    // dividend is ceiling << SCALE_FRAC_BITS; the quotient bits come out MSB first
    rem_s[0]  = ceil_q;
    quot_s[0] = '0;
  end

  for (genvar j = 0; j < SCALE_FRAC_BITS; j++) begin : g_div
    tdl_div_step #(
      .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (ready[j+2]),
      .item_i (item_s[j]),
      .rem_i  (rem_s[j]),
      .quot_i (quot_s[j]),
      .item_o (item_s[j+1]),
      .rem_o  (rem_s[j+1]),
      .quot_o (quot_s[j+1])
    );
  end

  // lanes, one per phase, form the output stage
  logic [PHASES-1:0][DUTY_W-1:0] lane_duty;
  tdl_action_e                   act_q;

  for (genvar p = 0; p < PHASES; p++) begin : g_lane
    tdl_lane #(
      .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (ready[LANE_S]),
      .duty_i   (item_s[SCALE_FRAC_BITS].duty[p]),
      .excess_i (item_s[SCALE_FRAC_BITS].excess),
      .factor_i (quot_s[SCALE_FRAC_BITS]),
      .action_i (item_s[SCALE_FRAC_BITS].action),
      .duty_o   (lane_duty[p])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ready[LANE_S]) begin
      act_q <= item_s[SCALE_FRAC_BITS].action;
    end
  end

  // merge lane results into the output transfer
  assign m_axis_tdata_o  = lane_duty;
  assign m_axis_tuser_o  = act_q;
  assign m_axis_tvalid_o = vld_q[LANE_S];

endmodule

`default_nettype wire

>>> src/tdl_checker.sv
// Port-level checker for the three-phase duty limiter, bound to the top level.
`default_nettype none

module tdl_checker import tdl_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic [47:0]       s_axis_tdata_i,
  input wire logic              s_axis_tvalid_i,
  input wire logic              s_axis_tready_o,
  input wire logic [47:0]       m_axis_tdata_o,
  input wire logic [1:0]        m_axis_tuser_o,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic [DUTY_W-1:0] cfg_data_i
);

  logic [DUTY_W-1:0] ceil_q;
  logic [DUTY_W-1:0] out_a, out_b, out_c, out_max;
  logic              in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= CEILING_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ceil_q <= cfg_data_i;
    end
  end

  always_comb begin
    in_xfer = s_axis_tvalid_i && s_axis_tready_o;
    out_a   = m_axis_tdata_o[15:0];
    out_b   = m_axis_tdata_o[31:16];
    out_c   = m_axis_tdata_o[47:32];
    out_max = (out_a > out_b) ? out_a : out_b;
    out_max = (out_c > out_max) ? out_c : out_max;
  end

  // nothing comes out while reset is held; valid may still be unknown at the first edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> m_axis_tvalid_o !== 1'b1)
    else $error("output valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output changed");

  // a limited triple never exceeds the ceiling
  a_limit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ACT_SHIFT || m_axis_tuser_o == ACT_SCALE)
      |-> out_max <= ceil_q)
    else $error("limited duty above ceiling");

  // a common-mode shift lands the largest phase exactly on the ceiling
  a_shift_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ACT_SHIFT |-> out_max == ceil_q)
    else $error("shifted peak not at ceiling");

  // transferred input data is never unknown
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !$isunknown(s_axis_tdata_i))
    else $error("unknown input data transferred");

endmodule

bind three_phase_duty_limiter tdl_checker u_tdl_checker (.*);

`default_nettype wire
